FILE: hdl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, frame byte indexes and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int unsigned IDX_W = 3;

    localparam logic [IDX_W-1:0] IDX_ADDR     = 3'd0;
    localparam logic [IDX_W-1:0] IDX_FUNC     = 3'd1;
    localparam logic [IDX_W-1:0] IDX_REG_HI   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_REG_LO   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_CNT_HI   = 3'd4;
    localparam logic [IDX_W-1:0] IDX_CNT_LO   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_CRC_LO   = 3'd6;
    localparam logic [IDX_W-1:0] IDX_CRC_HI   = 3'd7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] register_count;
    } mrf_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mrf_qstat_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

FILE: hdl/modbus_rtu_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Builds an 8-byte Modbus RTU request frame with CRC-16/MODBUS per request.
// ----------------------------------------------------------------------------
// Each accepted request produces eight frame_byte transfers: address, function,
// register address high/low, register count high/low, CRC low, CRC high, with
// last_byte set on the CRC high byte. The serializer emits one byte per cycle
// while out_ready does not stall it, and folds each header byte into the CRC as
// it is emitted; it finishes one request before starting the next. A request
// passes through the input stage register, the queue and the output byte
// register before its first byte appears; QUEUE_DEPTH requests (plus one in the
// input stage) can wait while the output is stalled.
module modbus_rtu_request_framer
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  slave_address,
    input  logic [7:0]  function_code,
    input  logic [15:0] register_address,
    input  logic [15:0] register_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    logic                push_valid;
    logic                push_ready;
    mrf_pkg::mrf_req_t   push_data;
    logic                head_valid;
    logic                head_pop;
    mrf_pkg::mrf_req_t   head_data;
    mrf_pkg::mrf_qstat_t q_stat;

    mrf_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .slave_address    (slave_address),
        .function_code    (function_code),
        .register_address (register_address),
        .register_count   (register_count),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_data        (push_data)
    );

    mrf_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head_data),
        .stat       (q_stat)
    );

    mrf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_pop   (head_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |-> !q_stat.full)
        else $error("queue pushed while full");

    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> push_valid)
        else $error("accepted request not held by input stage");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> (out_valid && last_byte))
        else $error("request retired without last byte on output");

endmodule

FILE: hdl/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// Input stage: takes a request and packs it into a header record for the queue.
// ----------------------------------------------------------------------------
module mrf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        slave_address,
    input  logic [7:0]        function_code,
    input  logic [15:0]       register_address,
    input  logic [15:0]       register_count,
    output logic              push_valid,
    input  logic              push_ready,
    output mrf_pkg::mrf_req_t push_data
);

    logic              valid_reg;
    logic              valid_next;
    mrf_pkg::mrf_req_t data_reg;
    logic              in_xfer;

    assign in_ready   = !valid_reg || push_ready;
    assign in_xfer    = in_valid && in_ready;
    assign valid_next = in_xfer || (valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            data_reg.slave_address    <= slave_address;
            data_reg.function_code    <= function_code;
            data_reg.register_address <= register_address;
            data_reg.register_count   <= register_count;
        end
    end

    assign push_valid = valid_reg;
    assign push_data  = data_reg;

endmodule

FILE: hdl/mrf_queue.sv
// ----------------------------------------------------------------------------
// mrf_queue
// Short request FIFO between the input stage and the byte serializer.
// ----------------------------------------------------------------------------
module mrf_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  mrf_pkg::mrf_req_t   push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mrf_pkg::mrf_req_t   pop_data,
    output mrf_pkg::mrf_qstat_t stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mrf_pkg::mrf_req_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// Byte serializer: walks the queued request one frame byte per transfer,
// folds each header byte into the CRC and appends the CRC low and high bytes.
// ----------------------------------------------------------------------------
module mrf_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  mrf_pkg::mrf_req_t head_data,
    output logic              head_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        frame_byte,
    output logic              last_byte
);

    logic [mrf_pkg::IDX_W-1:0] idx_reg;
    logic [mrf_pkg::IDX_W-1:0] idx_next;
    logic [15:0]               crc_reg;
    logic [15:0]               crc_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [7:0]                byte_reg;
    logic                      last_reg;
    logic [7:0]                byte_sel;
    logic                      is_last;
    logic                      fire;

    assign fire     = head_valid && (!out_valid_reg || out_ready);
    assign is_last  = (idx_reg == mrf_pkg::IDX_CRC_HI);
    assign head_pop = fire && is_last;

    always_comb
    begin
        unique case (idx_reg)
            mrf_pkg::IDX_ADDR:   byte_sel = head_data.slave_address;
            mrf_pkg::IDX_FUNC:   byte_sel = head_data.function_code;
            mrf_pkg::IDX_REG_HI: byte_sel = head_data.register_address[15:8];
            mrf_pkg::IDX_REG_LO: byte_sel = head_data.register_address[7:0];
            mrf_pkg::IDX_CNT_HI: byte_sel = head_data.register_count[15:8];
            mrf_pkg::IDX_CNT_LO: byte_sel = head_data.register_count[7:0];
            mrf_pkg::IDX_CRC_LO: byte_sel = crc_reg[7:0];
            mrf_pkg::IDX_CRC_HI: byte_sel = crc_reg[15:8];
            default:             byte_sel = '0;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (fire)
        begin
            idx_next = idx_reg + 1'b1;
            if (is_last)
            begin
                crc_next = mrf_pkg::CRC_INIT;
            end
            else if (idx_reg < mrf_pkg::IDX_CRC_LO)
            begin
                crc_next = mrf_pkg::crc_feed(crc_reg, byte_sel);
            end
        end
    end

    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= mrf_pkg::IDX_ADDR;
            crc_reg       <= mrf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg <= byte_sel;
            last_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

endmodule
